/* design/ssu_pkg.sv */
`timescale 1ns / 1ps

package ssu_pkg;

    // Fixed shape of the input and result words.
    localparam int unsigned TABLE_DEPTH = 16384;
    localparam int unsigned ADDR_W      = 14;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SLICE_W     = 31;
    localparam int unsigned ELEM_W      = 6;
    localparam int unsigned REGION_W    = 7;
    localparam int unsigned ROWS_W      = 9;
    localparam int unsigned CFG_IDX_W   = 3;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_SIZE   = 3'd0,
        CFG_BASE_OFFSET   = 3'd1,
        CFG_NUM_BASE      = 3'd2,
        CFG_UPDATE_MODE   = 3'd3,
        CFG_SIGNED_VALUES = 3'd4,
        CFG_SCALE         = 3'd5,
        CFG_UNUSED6       = 3'd6,
        CFG_UNUSED7       = 3'd7
    } t_cfg_idx;

    // Update mode codes.
    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_ADD = 1'b1;

    // Write-back request from the control to the table memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_mem_wr;

endpackage

/* design/ssu_table_ram.sv */
`timescale 1ns / 1ps

module ssu_table_ram #(
    parameter int unsigned DEPTH = 16384
) (
    input  logic                          i_clk,
    input  ssu_pkg::t_mem_wr              i_wr,
    input  logic [ssu_pkg::ADDR_W-1:0]    i_raddr,
    output logic [ssu_pkg::DATA_W-1:0]    o_rdata
);
    import ssu_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Single write port, single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.wdata;
        end
        r_rdata <= r_mem[i_raddr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/slice_scatter_update.sv */
`timescale 1ns / 1ps
// Each accepted word passes through accept, address/product, table read and write-back,
// and write-back waits until the result register is free. A new word is accepted only
// after write-back, set by the single read-modify-write pass through the table memory.
// Reset (i_rst_n low, synchronous) clears the control state and loads the
// configuration reset values; table contents are undefined until written.

module slice_scatter_update #(
    parameter int unsigned MAX_ROWS   = 256,
    parameter int unsigned MAX_REGION = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [ssu_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssu_pkg::DATA_W-1:0]      i_cfg_wdata,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_op,
    input  logic [ssu_pkg::ADDR_W-1:0]      i_word_address,
    input  logic [ssu_pkg::SLICE_W-1:0]     i_slice_index,
    input  logic [ssu_pkg::ELEM_W-1:0]      i_element,
    input  logic [ssu_pkg::DATA_W-1:0]      i_value,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ssu_pkg::DATA_W-1:0]      o_read_data,
    output logic                            o_applied,
    output logic                            o_out_of_range
);
    import ssu_pkg::*;

    // Usable depth: MAX_ROWS * MAX_REGION, capped at the table depth.
    localparam longint unsigned RAW_DEPTH = longint'(MAX_ROWS) * longint'(MAX_REGION);
    localparam int unsigned LIMIT =
        (RAW_DEPTH > longint'(TABLE_DEPTH)) ? TABLE_DEPTH : int'(RAW_DEPTH);
    localparam int unsigned DST_W = ROWS_W + REGION_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_READ,
        S_WB
    } t_state;

    // configuration registers
    logic [REGION_W-1:0] r_region_size;
    logic [SLICE_W-1:0]  r_base_offset;
    logic [ROWS_W-1:0]   r_num_base;
    logic                r_update_mode;
    logic                r_signed_values;
    logic [DATA_W-1:0]   r_scale;

    // captured input word
    t_state              r_state;
    t_op                 r_op;
    logic [ADDR_W-1:0]   r_addr;
    logic [SLICE_W-1:0]  r_slice;
    logic [ELEM_W-1:0]   r_elem;
    logic [DATA_W-1:0]   r_value;

    // results of the address stage
    logic [ADDR_W-1:0]   r_mem_addr;
    logic [DATA_W-1:0]   r_product;
    logic                r_do_write;
    logic                r_do_update;
    logic                r_do_read;
    logic                r_oor;

    // output register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_read_data;
    logic                r_out_applied;
    logic                r_out_oor;

    logic [DATA_W-1:0]   w_rdata;
    t_mem_wr             w_wr;
    logic                w_out_free;
    logic                w_accept;

    logic [DATA_W-1:0]   w_row;
    logic                w_row_held;
    logic                w_elem_bad;
    logic [DST_W-2:0]    w_row_off;
    logic [DST_W-1:0]    w_dst;
    logic                w_dst_bad;
    logic                w_addr_bad;
    logic [DATA_W-1:0]   w_product;
    logic [DATA_W-1:0]   w_merged;
    logic                w_new_bigger;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Address stage: row relative to the base, destination word, range checks.
    // A held row is below num_base_elements, so its low ROWS_W bits carry it fully.
    assign w_row      = {1'b0, r_slice} - {1'b0, r_base_offset};
    assign w_row_held = w_row < {{(DATA_W-ROWS_W){1'b0}}, r_num_base};
    assign w_elem_bad = {1'b0, r_elem} >= r_region_size;
    assign w_row_off  = {{(DST_W-1-ROWS_W){1'b0}}, w_row[ROWS_W-1:0]}
                        * {{(DST_W-1-REGION_W){1'b0}}, r_region_size};
    assign w_dst      = {1'b0, w_row_off} + {{(DST_W-ELEM_W){1'b0}}, r_elem};
    assign w_dst_bad  = w_dst >= DST_W'(LIMIT);
    assign w_addr_bad = {1'b0, r_addr} >= (ADDR_W+1)'(LIMIT);
    assign w_product  = DATA_W'(r_scale * r_value);

    // Merge stage: maximum (signed or unsigned) or scaled add with wrap.
    always_comb begin
        if (r_signed_values) begin
            w_new_bigger = $signed(r_value) > $signed(w_rdata);
        end else begin
            w_new_bigger = r_value > w_rdata;
        end
        if (r_update_mode == MODE_ADD) begin
            w_merged = w_rdata + r_product;
        end else begin
            w_merged = w_new_bigger ? r_value : w_rdata;
        end
    end

    // Write back only in the last stage, and only once the result can leave.
    always_comb begin
        w_wr.we    = (r_state == S_WB) && w_out_free && (r_do_write || r_do_update);
        w_wr.addr  = r_mem_addr;
        w_wr.wdata = r_do_update ? w_merged : r_value;
    end

    ssu_table_ram #(
        .DEPTH (LIMIT)
    ) u_table (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (r_mem_addr),
        .o_rdata (w_rdata)
    );

    // Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size   <= REGION_W'(1);
            r_base_offset   <= '0;
            r_num_base      <= '0;
            r_update_mode   <= MODE_MAX;
            r_signed_values <= 1'b1;
            r_scale         <= DATA_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REGION_SIZE:   r_region_size   <= i_cfg_wdata[REGION_W-1:0];
                CFG_BASE_OFFSET:   r_base_offset   <= i_cfg_wdata[SLICE_W-1:0];
                CFG_NUM_BASE:      r_num_base      <= i_cfg_wdata[ROWS_W-1:0];
                CFG_UPDATE_MODE:   r_update_mode   <= i_cfg_wdata[0];
                CFG_SIGNED_VALUES: r_signed_values <= i_cfg_wdata[0];
                CFG_SCALE:         r_scale         <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer: one word in flight, output register decoupled from the input.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= S_READ;
                end
                S_READ: begin
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(i_op);
            r_addr  <= i_word_address;
            r_slice <= i_slice_index;
            r_elem  <= i_element;
            r_value <= i_value;
        end
        if (r_state == S_CALC) begin
            r_product   <= w_product;
            r_do_write  <= 1'b0;
            r_do_update <= 1'b0;
            r_do_read   <= 1'b0;
            r_oor       <= 1'b0;
            r_mem_addr  <= r_addr;
            case (r_op)
                OP_WRITE, OP_READ: begin
                    if (w_addr_bad) begin
                        r_oor <= 1'b1;
                    end else begin
                        r_do_write <= (r_op == OP_WRITE);
                        r_do_read  <= (r_op == OP_READ);
                    end
                end
                OP_UPDATE: begin
                    r_mem_addr <= w_dst[ADDR_W-1:0];
                    if (w_row_held) begin
                        if (w_elem_bad || w_dst_bad) begin
                            r_oor <= 1'b1;
                        end else begin
                            r_do_update <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_WB && w_out_free) begin
            r_out_read_data <= r_do_read ? w_rdata : '0;
            r_out_applied   <= r_do_write || r_do_update;
            r_out_oor       <= r_oor;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_read_data;
    assign o_applied      = r_out_applied;
    assign o_out_of_range = r_out_oor;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_CALC)
        else $error("accepted word did not enter the address stage");

    a_write_only_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.we |-> (r_state == S_WB) && w_out_free)
        else $error("table written outside write-back");

    a_wb_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) && w_out_free |=> o_out_valid && (r_state == S_IDLE))
        else $error("write-back did not deliver a result");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_applied && o_out_of_range))
        else $error("applied and out_of_range both set");

    a_rdata_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_data != '0) |-> !o_applied && !o_out_of_range)
        else $error("read data on a word that was not a read");
`endif

endmodule
